// ===== sv/hgcd_pkg.sv =====
// shared constants, tables and cell data types for the great-circle distance block
`default_nettype none
package hgcd_pkg;

  // iteration counts
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  // register stages from input capture to the final product register
  localparam int PIPE_DEPTH   = 44 + 2 * CORDIC_STEPS;

  // datapath widths
  localparam int ROT_W = 34;
  localparam int VEC_W = 35;
  localparam int ANG_W = 34;

  // coordinate limits, degrees times 65536
  localparam logic signed [23:0] LAT_LIMIT = 24'sd5898240;
  localparam logic signed [24:0] LON_LIMIT = 25'sd11796480;

  // fixed-point constants
  localparam logic [31:0]             Q30_ONE     = 32'h4000_0000;
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [31:0]             PI_LO       = 32'd608135817;
  localparam logic [1:0]              PI_HI       = 2'd3;
  localparam logic [23:0]             RADIUS_RESET = 24'd6371000;

  // ceil(2^36 / d) reciprocals for exact division by 360 and 720
  localparam logic [27:0] RECIP_360 = 28'd190887436;
  localparam logic [27:0] RECIP_720 = 28'd95443718;
  localparam int          RECIP_SH  = 36;

  // arctangent of 2^-i in 32-bit turn fractions
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // rotation-mode cordic cell data
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic [1:0]              quad;
  } rot_t;

  // vectoring-mode cordic cell data
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  // square root cell data
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

endpackage
`default_nettype wire

// ===== sv/hgcd_turn.sv =====
// degree magnitude to signed turn-fraction angle, exact rounded division by 360 or 720
`default_nettype none
module hgcd_turn import hgcd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic        half,
  input  logic [25:0] mag,
  input  logic        neg,
  output logic [31:0] angle
);

  logic [27:0] recip;
  logic [9:0]  dv;
  logic [9:0]  hv;
  logic [53:0] p1;
  logic [53:0] p3;
  logic [25:0] ra;
  logic [33:0] q;

  logic [17:0] qa1_r, qa2_r, qa3_r;
  logic [25:0] mag1_r;
  logic [25:0] x2_r;
  logic [16:0] qb3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] angle_r;

  // divisor, half divisor and reciprocal
  assign recip = half ? RECIP_720 : RECIP_360;
  assign dv    = half ? 10'd720 : 10'd360;
  assign hv    = half ? 10'd360 : 10'd180;

  // coarse quotient, remainder, fine quotient
  assign p1 = 54'(mag) * 54'(recip);
  assign ra = mag1_r - 26'(28'(qa1_r) * 28'(dv));
  assign p3 = 54'(x2_r) * 54'(recip);
  assign q  = (34'(qa3_r) << 16) + 34'(qb3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qa1_r   <= p1[53:RECIP_SH];
      mag1_r  <= mag;
      neg1_r  <= neg;
      qa2_r   <= qa1_r;
      x2_r    <= {ra[9:0], 16'b0} + 26'(hv);
      neg2_r  <= neg1_r;
      qa3_r   <= qa2_r;
      qb3_r   <= p3[52:RECIP_SH];
      neg3_r  <= neg2_r;
      angle_r <= neg3_r ? 32'd0 - q[31:0] : q[31:0];
    end
  end

  assign angle = angle_r;

endmodule
`default_nettype wire

// ===== sv/hgcd_rot_cell.sv =====
// one rotation-mode cordic iteration with its own register
`default_nettype none
module hgcd_rot_cell import hgcd_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  rot_t       cell_i,
  output rot_t       cell_o
);

  rot_t                    cell_nxt;
  rot_t                    cell_r;
  logic signed [ROT_W-1:0] xs;
  logic signed [ROT_W-1:0] ys;
  logic signed [ANG_W-1:0] ang;

  // rotate toward zero residual angle
  always_comb begin
    xs       = cell_i.x >>> step;
    ys       = cell_i.y >>> step;
    ang      = $signed({2'b00, ATAN_TURNS[step]});
    cell_nxt = cell_i;
    if (!cell_i.z[ANG_W-1]) begin
      cell_nxt.x = cell_i.x - ys;
      cell_nxt.y = cell_i.y + xs;
      cell_nxt.z = cell_i.z - ang;
    end else begin
      cell_nxt.x = cell_i.x + ys;
      cell_nxt.y = cell_i.y - xs;
      cell_nxt.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// ===== sv/hgcd_sqrt_cell.sv =====
// one digit of the restoring integer square root with its own register
`default_nettype none
module hgcd_sqrt_cell import hgcd_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [5:0] bit_pos,
  input  sqrt_t      cell_i,
  output sqrt_t      cell_o
);

  sqrt_t       cell_nxt;
  sqrt_t       cell_r;
  logic [63:0] one_bit;
  logic [63:0] trial;

  // try the next root digit
  always_comb begin
    one_bit = 64'd1 << bit_pos;
    trial   = cell_i.root + one_bit;
    if (cell_i.rem >= trial) begin
      cell_nxt.rem  = cell_i.rem - trial;
      cell_nxt.root = (cell_i.root >> 1) + one_bit;
    end else begin
      cell_nxt.rem  = cell_i.rem;
      cell_nxt.root = cell_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// ===== sv/hgcd_vec_cell.sv =====
// one vectoring-mode cordic iteration with its own register
`default_nettype none
module hgcd_vec_cell import hgcd_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] step,
  input  vec_t       cell_i,
  output vec_t       cell_o
);

  vec_t                    cell_nxt;
  vec_t                    cell_r;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [ANG_W-1:0] ang;

  // rotate the vector toward the x axis, summing the angle
  always_comb begin
    xs  = cell_i.x >>> step;
    ys  = cell_i.y >>> step;
    ang = $signed({2'b00, ATAN_TURNS[step]});
    if (!cell_i.y[VEC_W-1]) begin
      cell_nxt.x = cell_i.x + ys;
      cell_nxt.y = cell_i.y - xs;
      cell_nxt.z = cell_i.z + ang;
    end else begin
      cell_nxt.x = cell_i.x - ys;
      cell_nxt.y = cell_i.y + xs;
      cell_nxt.z = cell_i.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// ===== sv/haversine_great_circle_distance_top.sv =====
// haversine great-circle distance, fully pipelined cordic and square-root cell chains
//
// Input channel (in_valid/in_ready) takes one request: two positions, each latitude
// and longitude in signed degrees times 65536. Output channel (out_valid/out_ready)
// gives the distance in whole meters and an out-of-range flag; a flagged result
// has distance zero.
// The radius register is written through cfg_wr_en/cfg_wr_data and resets to
// 6371000 m; write it only while no request is in flight.
// An accepted request passes the input capture register, the turn conversion, two
// cordic chains of CORDIC_STEPS cells, a 32-cell square root chain, the multiply
// stages and the output register before out_valid rises.
// Throughput: one request per cycle while the receiver does not stall; every stage is a register of its own.
// When the receiver stalls, the whole pipeline holds and in_ready drops only while a
// finished result waits in the output register and out_ready is low.
// Reset (rst_n low, synchronous) empties the pipeline and restores the radius.
`default_nettype none
module haversine_great_circle_distance_top import hgcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_first_latitude,
  input  logic signed [24:0] in_first_longitude,
  input  logic signed [23:0] in_second_latitude,
  input  logic signed [24:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        out_distance_m,
  output logic               out_out_of_range,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // clamp a cordic output to +-1.0
  function automatic logic signed [31:0] clamp_q30(input logic signed [ROT_W-1:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // cosine by quadrant, clamped to [0, 1.0]
  function automatic logic [30:0] cos_pos(input rot_t c);
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] r;
    cx = clamp_q30(c.x);
    cy = clamp_q30(c.y);
    unique case (c.quad)
      QUAD_0:  r = cx;
      QUAD_1:  r = -cy;
      QUAD_2:  r = -cx;
      QUAD_3:  r = cy;
      default: r = cx;
    endcase
    return r[31] ? 31'd0 : r[30:0];
  endfunction

  // sine magnitude by quadrant
  function automatic logic [30:0] sin_mag(input rot_t c);
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] r;
    cx = clamp_q30(c.x);
    cy = clamp_q30(c.y);
    unique case (c.quad)
      QUAD_0:  r = cy;
      QUAD_1:  r = cx;
      QUAD_2:  r = -cy;
      QUAD_3:  r = -cx;
      default: r = cy;
    endcase
    return r[31] ? 31'(-r) : r[30:0];
  endfunction

  // fold the angle into +-45 degrees and seed the rotation
  function automatic rot_t rot_seed(input logic [31:0] a);
    rot_t        s;
    logic [31:0] sum;
    logic [31:0] v;
    sum    = a + 32'h2000_0000;
    s.quad = sum[31:30];
    v      = a - {s.quad, 30'b0};
    s.x    = CORDIC_GAIN;
    s.y    = '0;
    s.z    = ANG_W'($signed(v));
    return s;
  endfunction

  // q30 product, rounded half up
  function automatic logic [30:0] mul_q30(input logic [30:0] p, input logic [30:0] q);
    logic [61:0] prod;
    logic [61:0] rnd;
    prod = 62'(p) * 62'(q);
    rnd  = prod + 62'(32'h2000_0000);
    return rnd[60:30];
  endfunction

  logic        en;
  logic [23:0] radius_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [PIPE_DEPTH-1:0] oor_r;
  logic                  oor_in;

  // input capture stage
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  logic [25:0]        mag_r [4];
  logic               neg_r [4];
  logic [25:0]        mag_nxt [4];
  logic               neg_nxt [4];
  logic [31:0]        angle [4];

  // cell chains
  rot_t  rot_c [4][CORDIC_STEPS+1];
  sqrt_t sa_c [SQRT_STEPS+1];
  sqrt_t sb_c [SQRT_STEPS+1];
  vec_t  vec_c [CORDIC_STEPS+1];

  // arithmetic stages
  logic [30:0] c1_r, c2_r, s1_r, s2_r;
  logic [30:0] sq1_r, cc_r, sq2_r;
  logic [30:0] sq1b_r, t_r;
  logic [31:0] asum;
  logic [30:0] a_nxt;
  logic [30:0] a_r, na_r;
  logic signed [ANG_W-1:0] zf;
  logic [30:0] zc;
  logic [62:0] plo_r;
  logic [30:0] zc_r;
  logic [65:0] usum;
  logic [33:0] u_r;
  logic [57:0] prod_r;
  logic [58:0] drnd;

  logic        out_valid_r;
  logic [25:0] out_dist_r;
  logic        out_oor_r;

  // pipeline advances unless a finished result is stuck
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // range check and magnitudes of the four angles
  always_comb begin
    oor_in = (in_first_latitude > LAT_LIMIT) || (in_first_latitude < -LAT_LIMIT) ||
             (in_second_latitude > LAT_LIMIT) || (in_second_latitude < -LAT_LIMIT) ||
             (in_first_longitude > LON_LIMIT) || (in_first_longitude < -LON_LIMIT) ||
             (in_second_longitude > LON_LIMIT) || (in_second_longitude < -LON_LIMIT);
    dlat = 25'(in_first_latitude) - 25'(in_second_latitude);
    dlon = 26'(in_first_longitude) - 26'(in_second_longitude);
    neg_nxt[0] = in_first_latitude[23];
    neg_nxt[1] = in_second_latitude[23];
    neg_nxt[2] = dlat[24];
    neg_nxt[3] = dlon[25];
    mag_nxt[0] = 26'(neg_nxt[0] ? 24'(-in_first_latitude) : 24'(in_first_latitude));
    mag_nxt[1] = 26'(neg_nxt[1] ? 24'(-in_second_latitude) : 24'(in_second_latitude));
    mag_nxt[2] = 26'(neg_nxt[2] ? 25'(-dlat) : 25'(dlat));
    mag_nxt[3] = neg_nxt[3] ? 26'(-dlon) : 26'(dlon);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag_r[k] <= mag_nxt[k];
        neg_r[k] <= neg_nxt[k];
      end
    end
  end

  // request valid and range flag travel beside the data
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r <= {oor_r[PIPE_DEPTH-2:0], oor_in};
    end
  end

  // turn conversion and sine/cosine chains: latitudes first, half differences next
  for (genvar k = 0; k < 4; k++) begin : g_angle
    hgcd_turn u_turn (
      .clk   (clk),
      .en    (en),
      .half  (k >= 2),
      .mag   (mag_r[k]),
      .neg   (neg_r[k]),
      .angle (angle[k])
    );

    assign rot_c[k][0] = rot_seed(angle[k]);

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      hgcd_rot_cell u_cell (
        .clk    (clk),
        .en     (en),
        .step   (5'(i)),
        .cell_i (rot_c[k][i]),
        .cell_o (rot_c[k][i+1])
      );
    end
  end

  // haversine term
  always_comb begin
    asum  = {1'b0, sq1b_r} + {1'b0, t_r};
    a_nxt = (asum > Q30_ONE) ? Q30_ONE[30:0] : asum[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= cos_pos(rot_c[0][CORDIC_STEPS]);
      c2_r   <= cos_pos(rot_c[1][CORDIC_STEPS]);
      s1_r   <= sin_mag(rot_c[2][CORDIC_STEPS]);
      s2_r   <= sin_mag(rot_c[3][CORDIC_STEPS]);
      sq1_r  <= mul_q30(s1_r, s1_r);
      cc_r   <= mul_q30(c1_r, c2_r);
      sq2_r  <= mul_q30(s2_r, s2_r);
      sq1b_r <= sq1_r;
      t_r    <= mul_q30(cc_r, sq2_r);
      a_r    <= a_nxt;
      na_r   <= Q30_ONE[30:0] - a_nxt;
    end
  end

  // square roots of a and 1 - a
  assign sa_c[0] = '{rem: {3'b0, a_r, 30'b0}, root: 64'd0};
  assign sb_c[0] = '{rem: {3'b0, na_r, 30'b0}, root: 64'd0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    hgcd_sqrt_cell u_sa (
      .clk     (clk),
      .en      (en),
      .bit_pos (6'(62 - 2 * k)),
      .cell_i  (sa_c[k]),
      .cell_o  (sa_c[k+1])
    );
    hgcd_sqrt_cell u_sb (
      .clk     (clk),
      .en      (en),
      .bit_pos (6'(62 - 2 * k)),
      .cell_i  (sb_c[k]),
      .cell_o  (sb_c[k+1])
    );
  end

  // atan2 of the two roots
  assign vec_c[0] = '{x: $signed({4'b0, sb_c[SQRT_STEPS].root[30:0]}),
                      y: $signed({4'b0, sa_c[SQRT_STEPS].root[30:0]}),
                      z: '0};

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    hgcd_vec_cell u_cell (
      .clk    (clk),
      .en     (en),
      .step   (5'(i)),
      .cell_i (vec_c[i]),
      .cell_o (vec_c[i+1])
    );
  end

  // central angle to radians, then scale by the radius
  always_comb begin
    zf = vec_c[CORDIC_STEPS].z;
    if (zf[ANG_W-1]) begin
      zc = '0;
    end else if (zf > $signed({2'b00, Q30_ONE})) begin
      zc = Q30_ONE[30:0];
    end else begin
      zc = zf[30:0];
    end
    usum = 66'(plo_r) + ((66'(zc_r) * 66'(PI_HI)) << 32) + 66'(32'h2000_0000);
    drnd = 59'(prod_r) + (59'(1) << 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r  <= 63'(zc) * 63'(PI_LO);
      zc_r   <= zc;
      u_r    <= usum[63:30];
      prod_r <= 58'(u_r) * 58'(radius_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= oor_r[PIPE_DEPTH-1] ? 26'd0 : drnd[57:32];
      out_oor_r  <= oor_r[PIPE_DEPTH-1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance_m   = out_dist_r;
  assign out_out_of_range = out_oor_r;

endmodule
`default_nettype wire
